// File: design/dll_pkg.sv
// Shared constants, codes and helpers for the linked list engine.
// No dependencies; used only by the top level.
package dll_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY + 1);
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(CAPACITY);

   typedef enum logic [3:0] {
      ACT_INS_FRONT = 4'd0,
      ACT_INS_BACK  = 4'd1,
      ACT_INS_AT    = 4'd2,
      ACT_DEL_FRONT = 4'd3,
      ACT_DEL_BACK  = 4'd4,
      ACT_DEL_AT    = 4'd5,
      ACT_REVERSE   = 4'd6,
      ACT_NTH       = 4'd7,
      ACT_LAST      = 4'd8,
      ACT_SEARCH    = 4'd9,
      ACT_MIDDLE    = 4'd10,
      ACT_CLEAR     = 4'd11,
      ACT_DUMP_FWD  = 4'd12,
      ACT_DUMP_REV  = 4'd13
   } act_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // Sign-extend a stored word and cut it to the 32-bit result field.
   function automatic logic [31:0] res_word(input logic [DATA_WIDTH-1:0] d);
      logic signed [DATA_WIDTH-1:0] s;
      logic signed [63:0] w;
      s = d;
      w = 64'(s);
      return w[31:0];
   endfunction

endpackage

// File: design/doubly_linked_list_engine_top.sv
// Bounded doubly linked list of signed words held in three RAMs.
// Depends on dll_pkg and dll_ram.
//
//   channel   ports                       handshake
//   request   req_action/position/value   start & !busy
//   response  rsp_* fields                rsp_strobe, one cycle, no stall
//
// Front/back inserts pass through S_LINK1 and S_LINK2, front/back deletes through
// S_WALK and S_FIN; reverse and clear answer straight from S_IDLE. Positional
// actions, nth and middle walk one link per cycle, a rate set by the single read
// port of the link RAMs. Search and dumps run in S_SCAN, where a dump delivers
// one beat per cycle. Reverse flips a direction flag and swaps head and tail.
// Reset is synchronous and clears the list at once; RAM contents are don't-care.
module doubly_linked_list_engine_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_action,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_value_res,
   output logic               rsp_found,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_count,
   output logic               rsp_is_empty,
   output logic               rsp_last
);

   localparam int IW = dll_pkg::IDX_W;
   localparam int AW = dll_pkg::ADDR_W;
   localparam int DW = dll_pkg::DATA_WIDTH;
   localparam int CP = dll_pkg::CAPACITY;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_WALK  = 6'b000010,
      S_FIN   = 6'b000100,
      S_LINK1 = 6'b001000,
      S_LINK2 = 6'b010000,
      S_SCAN  = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   dll_pkg::act_type act_ff, act_in;
   logic [DW-1:0]    val_ff, val_in;
   logic [IW-1:0]    cur_ff, cur_in;
   logic [6:0]       steps_ff, steps_in;
   logic             pend_ff, pend_in;
   logic             dir_ff, dir_in;
   logic [IW-1:0]    before_ff, before_in;
   logic [IW-1:0]    after_ff, after_in;
   logic [IW-1:0]    head_ff, head_in;
   logic [IW-1:0]    tail_ff, tail_in;
   logic [IW-1:0]    count_ff, count_in;
   logic [CP-1:0]    slot_ff, slot_in;
   logic             rev_ff, rev_in;
   logic             strobe_ff, strobe_in;
   logic [31:0]      rval_ff, rval_in;
   logic             rfound_ff, rfound_in;
   logic [1:0]       rstat_ff, rstat_in;
   logic             rlast_ff, rlast_in;

   // RAM ports
   logic [AW-1:0]    rd_addr;
   logic [DW-1:0]    data_rd;
   logic [IW-1:0]    a_rd, b_rd;
   logic             data_we;
   logic [AW-1:0]    data_wa;
   logic             nx_we, pv_we;
   logic [AW-1:0]    nx_wa, pv_wa;
   logic [IW-1:0]    nx_wd, pv_wd;
   logic             a_we, b_we;
   logic [AW-1:0]    a_wa, b_wa;
   logic [IW-1:0]    a_wd, b_wd;

   logic [IW-1:0]    lnext_rd, lprev_rd, ldir_rd, cur_now;
   logic [AW-1:0]    alloc;
   logic [DW-1:0]    vin;
   logic signed [63:0] v64;
   logic [7:0]       pos8, cnt8;

   dll_ram #(.WIDTH(DW), .DEPTH(CP)) u_data (
      .clock(clock), .we(data_we), .waddr(data_wa), .wdata(val_ff),
      .raddr(rd_addr), .rdata(data_rd));
   dll_ram #(.WIDTH(IW), .DEPTH(CP)) u_link_a (
      .clock(clock), .we(a_we), .waddr(a_wa), .wdata(a_wd),
      .raddr(rd_addr), .rdata(a_rd));
   dll_ram #(.WIDTH(IW), .DEPTH(CP)) u_link_b (
      .clock(clock), .we(b_we), .waddr(b_wa), .wdata(b_wd),
      .raddr(rd_addr), .rdata(b_rd));

   // Map logical next/prev onto the physical link RAMs by direction.
   assign lnext_rd = rev_ff ? b_rd : a_rd;
   assign lprev_rd = rev_ff ? a_rd : b_rd;
   assign ldir_rd  = dir_ff ? lprev_rd : lnext_rd;
   assign a_we = rev_ff ? pv_we : nx_we;
   assign a_wa = rev_ff ? pv_wa : nx_wa;
   assign a_wd = rev_ff ? pv_wd : nx_wd;
   assign b_we = rev_ff ? nx_we : pv_we;
   assign b_wa = rev_ff ? nx_wa : pv_wa;
   assign b_wd = rev_ff ? nx_wd : pv_wd;

   assign v64  = 64'(req_value);
   assign vin  = v64[DW-1:0];
   assign pos8 = {1'b0, req_position};
   assign cnt8 = 8'(count_ff);
   assign cur_now = pend_ff ? ldir_rd : cur_ff;

   // Lowest free slot.
   always_comb begin
      alloc = '0;
      for (int i = CP - 1; i >= 0; i--) begin
         if (!slot_ff[i]) begin
            alloc = AW'(i);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      val_in    = val_ff;
      cur_in    = cur_ff;
      steps_in  = steps_ff;
      pend_in   = pend_ff;
      dir_in    = dir_ff;
      before_in = before_ff;
      after_in  = after_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      slot_in   = slot_ff;
      rev_in    = rev_ff;
      strobe_in = 1'b0;
      rval_in   = '0;
      rfound_in = 1'b0;
      rstat_in  = dll_pkg::ST_OK;
      rlast_in  = 1'b1;
      rd_addr   = cur_now[AW-1:0];
      data_we   = 1'b0;
      data_wa   = alloc;
      nx_we     = 1'b0;
      nx_wa     = alloc;
      nx_wd     = after_ff;
      pv_we     = 1'b0;
      pv_wa     = alloc;
      pv_wd     = before_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in  = dll_pkg::act_type'(req_action);
               val_in  = vin;
               pend_in = 1'b0;
               cur_in  = head_ff;
               case (dll_pkg::act_type'(req_action))
                  dll_pkg::ACT_INS_FRONT, dll_pkg::ACT_INS_BACK: begin
                     if (count_ff == IW'(CP)) begin
                        strobe_in = 1'b1;
                        rstat_in  = dll_pkg::ST_FULL;
                     end else if (req_action == 4'(dll_pkg::ACT_INS_FRONT)) begin
                        before_in = dll_pkg::NULL_IDX;
                        after_in  = head_ff;
                        state_in  = S_LINK1;
                     end else begin
                        before_in = tail_ff;
                        after_in  = dll_pkg::NULL_IDX;
                        state_in  = S_LINK1;
                     end
                  end
                  dll_pkg::ACT_INS_AT: begin
                     if (pos8 == 8'd0 || pos8 > cnt8 + 8'd1) begin
                        strobe_in = 1'b1;
                        rstat_in  = dll_pkg::ST_RANGE;
                     end else if (count_ff == IW'(CP)) begin
                        strobe_in = 1'b1;
                        rstat_in  = dll_pkg::ST_FULL;
                     end else if (pos8 == 8'd1) begin
                        before_in = dll_pkg::NULL_IDX;
                        after_in  = head_ff;
                        state_in  = S_LINK1;
                     end else begin
                        steps_in = req_position - 7'd2;
                        state_in = S_WALK;
                     end
                  end
                  dll_pkg::ACT_DEL_FRONT, dll_pkg::ACT_DEL_BACK, dll_pkg::ACT_LAST: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        rstat_in  = dll_pkg::ST_EMPTY;
                     end else begin
                        if (req_action != 4'(dll_pkg::ACT_DEL_FRONT)) begin
                           cur_in = tail_ff;
                        end
                        steps_in = '0;
                        state_in = S_WALK;
                     end
                  end
                  dll_pkg::ACT_DEL_AT, dll_pkg::ACT_NTH: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        rstat_in  = dll_pkg::ST_EMPTY;
                     end else if (pos8 == 8'd0 || pos8 > cnt8) begin
                        strobe_in = 1'b1;
                        rstat_in  = dll_pkg::ST_RANGE;
                     end else begin
                        steps_in = req_position - 7'd1;
                        state_in = S_WALK;
                     end
                  end
                  dll_pkg::ACT_MIDDLE: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        rstat_in  = dll_pkg::ST_EMPTY;
                     end else begin
                        steps_in = 7'(count_ff >> 1);
                        state_in = S_WALK;
                     end
                  end
                  dll_pkg::ACT_REVERSE: begin
                     rev_in    = !rev_ff;
                     head_in   = tail_ff;
                     tail_in   = head_ff;
                     strobe_in = 1'b1;
                  end
                  dll_pkg::ACT_SEARCH: begin
                     dir_in   = 1'b0;
                     state_in = S_SCAN;
                  end
                  dll_pkg::ACT_CLEAR: begin
                     slot_in   = '0;
                     head_in   = dll_pkg::NULL_IDX;
                     tail_in   = dll_pkg::NULL_IDX;
                     count_in  = '0;
                     strobe_in = 1'b1;
                  end
                  dll_pkg::ACT_DUMP_FWD, dll_pkg::ACT_DUMP_REV: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        rstat_in  = dll_pkg::ST_EMPTY;
                     end else begin
                        dir_in   = (req_action == 4'(dll_pkg::ACT_DUMP_REV));
                        cur_in   = (req_action == 4'(dll_pkg::ACT_DUMP_REV)) ? tail_ff
                                                                            : head_ff;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                     rstat_in  = dll_pkg::ST_RANGE;
                  end
               endcase
            end
         end
         S_WALK: begin
            // Chain the read address straight from the returned next link.
            cur_in  = cur_now;
            dir_in  = 1'b0;
            pend_in = 1'b1;
            if (steps_ff == '0) begin
               pend_in  = 1'b0;
               state_in = S_FIN;
            end else begin
               steps_in = steps_ff - 7'd1;
            end
         end
         S_FIN: begin
            state_in = S_IDLE;
            case (act_ff)
               dll_pkg::ACT_INS_AT: begin
                  before_in = cur_ff;
                  after_in  = lnext_rd;
                  state_in  = S_LINK1;
               end
               dll_pkg::ACT_DEL_FRONT, dll_pkg::ACT_DEL_BACK, dll_pkg::ACT_DEL_AT: begin
                  // Unlink cur: prev.next = next, next.prev = prev.
                  nx_wa = lprev_rd[AW-1:0];
                  nx_wd = lnext_rd;
                  pv_wa = lnext_rd[AW-1:0];
                  pv_wd = lprev_rd;
                  if (lprev_rd != dll_pkg::NULL_IDX) begin
                     nx_we = 1'b1;
                  end else begin
                     head_in = lnext_rd;
                  end
                  if (lnext_rd != dll_pkg::NULL_IDX) begin
                     pv_we = 1'b1;
                  end else begin
                     tail_in = lprev_rd;
                  end
                  slot_in[cur_ff[AW-1:0]] = 1'b0;
                  count_in  = count_ff - IW'(1);
                  strobe_in = 1'b1;
               end
               default: begin
                  rval_in   = dll_pkg::res_word(data_rd);
                  strobe_in = 1'b1;
               end
            endcase
         end
         S_LINK1: begin
            data_we  = 1'b1;
            nx_we    = 1'b1;
            pv_we    = 1'b1;
            state_in = S_LINK2;
         end
         S_LINK2: begin
            nx_wa = before_ff[AW-1:0];
            nx_wd = IW'(alloc);
            pv_wa = after_ff[AW-1:0];
            pv_wd = IW'(alloc);
            if (before_ff != dll_pkg::NULL_IDX) begin
               nx_we = 1'b1;
            end else begin
               head_in = IW'(alloc);
            end
            if (after_ff != dll_pkg::NULL_IDX) begin
               pv_we = 1'b1;
            end else begin
               tail_in = IW'(alloc);
            end
            slot_in[alloc] = 1'b1;
            count_in  = count_ff + IW'(1);
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         S_SCAN: begin
            cur_in  = cur_now;
            pend_in = 1'b1;
            if (act_ff == dll_pkg::ACT_SEARCH) begin
               if (pend_ff && data_rd == val_ff) begin
                  strobe_in = 1'b1;
                  rfound_in = 1'b1;
                  state_in  = S_IDLE;
               end else if (cur_now == dll_pkg::NULL_IDX) begin
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               // Emit one beat per node as its data returns.
               if (pend_ff) begin
                  strobe_in = 1'b1;
                  rval_in   = dll_pkg::res_word(data_rd);
                  rlast_in  = (cur_now == dll_pkg::NULL_IDX);
               end
               if (cur_now == dll_pkg::NULL_IDX) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= dll_pkg::NULL_IDX;
         tail_ff   <= dll_pkg::NULL_IDX;
         count_ff  <= '0;
         slot_ff   <= '0;
         rev_ff    <= 1'b0;
         strobe_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         slot_ff   <= slot_in;
         rev_ff    <= rev_in;
         strobe_ff <= strobe_in;
         pend_ff   <= pend_in;
      end
      act_ff    <= act_in;
      val_ff    <= val_in;
      cur_ff    <= cur_in;
      steps_ff  <= steps_in;
      dir_ff    <= dir_in;
      before_ff <= before_in;
      after_ff  <= after_in;
      rval_ff   <= rval_in;
      rfound_ff <= rfound_in;
      rstat_ff  <= rstat_in;
      rlast_ff  <= rlast_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_value_res = rval_ff;
   assign rsp_found     = rfound_ff;
   assign rsp_status    = rstat_ff;
   assign rsp_count     = 7'(count_ff);
   assign rsp_is_empty  = (count_ff == '0);
   assign rsp_last      = rlast_ff;

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IW'(CP))
      else $error("entry count above capacity");
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == dll_pkg::NULL_IDX && tail_ff == dll_pkg::NULL_IDX)
      else $error("empty list with a live head or tail");
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == dll_pkg::ST_FULL |-> count_ff == IW'(CP))
      else $error("full status on a list that is not full");
   a_slots: assert property (@(posedge clock) disable iff (reset)
      $countones(slot_ff) == int'(count_ff))
      else $error("slot map disagrees with entry count");
`endif

endmodule

// File: design/dll_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
